### sv/utf8_to_json_string_escape_macros.svh
// assertion macros for the utf8 to json string escaper
`ifndef UTF8_TO_JSON_STRING_ESCAPE_MACROS_SVH
`define UTF8_TO_JSON_STRING_ESCAPE_MACROS_SVH

// same-cycle implication, checked at every rising clock edge out of reset
`define U8JSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define U8JSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/u8jse_pkg.sv
// shared types, codes and helpers for the utf8 to json string escaper
package u8jse_pkg;

  localparam int unsigned ActionW = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CharW   = 7;
  localparam int unsigned CodeW   = 21;

  // action codes
  localparam logic [ActionW-1:0] ACT_BEGIN = 2'd0;
  localparam logic [ActionW-1:0] ACT_DATA  = 2'd1;
  localparam logic [ActionW-1:0] ACT_END   = 2'd2;

  // ascii characters used by the escaper
  localparam logic [CharW-1:0] CH_QUOTE  = 7'h22;
  localparam logic [CharW-1:0] CH_BSLASH = 7'h5C;
  localparam logic [CharW-1:0] CH_U      = 7'h75;
  localparam logic [CharW-1:0] CH_B      = 7'h62;
  localparam logic [CharW-1:0] CH_F      = 7'h66;
  localparam logic [CharW-1:0] CH_N      = 7'h6E;
  localparam logic [CharW-1:0] CH_R      = 7'h72;
  localparam logic [CharW-1:0] CH_T      = 7'h74;

  // code points
  localparam logic [CodeW-1:0] CP_BS      = 21'h08;
  localparam logic [CodeW-1:0] CP_TAB     = 21'h09;
  localparam logic [CodeW-1:0] CP_LF      = 21'h0A;
  localparam logic [CodeW-1:0] CP_FF      = 21'h0C;
  localparam logic [CodeW-1:0] CP_CR      = 21'h0D;
  localparam logic [CodeW-1:0] CP_QUOTE   = 21'h22;
  localparam logic [CodeW-1:0] CP_BSLASH  = 21'h5C;
  localparam logic [CodeW-1:0] CP_PRT_LO  = 21'h20;
  localparam logic [CodeW-1:0] CP_PRT_HI  = 21'h7F;
  localparam logic [CodeW-1:0] CP_REPL    = 21'h00FFFD;
  localparam logic [CodeW-1:0] CP_SUPP    = 21'h010000;

  // lead byte ranges
  localparam logic [ByteW-1:0] LEAD2_LO = 8'hC2;
  localparam logic [ByteW-1:0] LEAD2_HI = 8'hDF;
  localparam logic [ByteW-1:0] LEAD3_LO = 8'hE0;
  localparam logic [ByteW-1:0] LEAD3_HI = 8'hEF;
  localparam logic [ByteW-1:0] LEAD4_LO = 8'hF0;
  localparam logic [ByteW-1:0] LEAD4_HI = 8'hF4;
  localparam logic [ByteW-1:0] ASCII_HI = 8'h7F;

  // surrogate prefixes (top six bits of d800 and dc00)
  localparam logic [5:0] SURR_HI_PFX = 6'b110110;
  localparam logic [5:0] SURR_LO_PFX = 6'b110111;

  // how a decoded code point is written out
  typedef enum logic [2:0] {
    K_NONE,
    K_ESC,
    K_LIT,
    K_HEX,
    K_PAIR
  } cp_kind_e;

  // lowercase hex digit
  function automatic logic [CharW-1:0] hex_digit(input logic [3:0] nib);
    logic [CharW-1:0] wide;
    wide = {3'b000, nib};
    if (nib < 4'd10) begin
      return 7'h30 + wide;
    end else begin
      return 7'h57 + wide;
    end
  endfunction

endpackage

### sv/u8jse_if.sv
// valid/ready channel interfaces for the escaper input and output
interface u8jse_in_if
  import u8jse_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [ByteW-1:0]   in_byte;

  modport source (output valid, output action, output in_byte, input ready);
  modport sink   (input valid, input action, input in_byte, output ready);
endinterface

interface u8jse_out_if
  import u8jse_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] out_char;
  logic             run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

### sv/utf8_to_json_string_escape.sv
// utf8 to json quoted string escaper, one byte in, a run of ascii characters out
// the first character of a transaction's run goes through the run register, then the output register
// throughput: one input transaction per cycle while each gives at most one character and out_o is
//   not stalled; a longer run (at most 12 characters) holds the input until its last character is loaded
// the run register and the one-character output register bound the rate
// reset clears the decoder state, the pending run and the output register
`include "utf8_to_json_string_escape_macros.svh"

module utf8_to_json_string_escape
  import u8jse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  u8jse_in_if.sink    in_i,
  u8jse_out_if.source out_o
);

  // utf-8 decoder state
  logic [1:0]       bytes_pending_q, bytes_pending_d;
  logic [CodeW-1:0] code_accum_q, code_accum_d;

  // run register: everything needed to spell out one transaction's characters
  logic             run_valid_q, run_valid_d;
  cp_kind_e         run_kind_q, run_kind_d;
  logic [3:0]       run_cp_len_q, run_cp_len_d;
  logic [3:0]       run_len_q, run_len_d;
  logic [3:0]       run_idx_q, run_idx_d;
  logic [15:0]      run_w0_q, run_w0_d;
  logic [15:0]      run_w1_q, run_w1_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [CharW-1:0] out_char_q, out_char_d;
  logic             out_last_q, out_last_d;

  logic             in_acc;
  logic             load;
  logic             run_at_last;

  // decode of the accepted transaction
  logic             emit_cp;
  logic             emit_quote;
  logic [CodeW-1:0] cp;
  logic [CodeW-1:0] acc_shift;
  logic [1:0]       pend_dec;
  logic [CharW-1:0] esc_char;
  logic [CodeW-1:0] supp_off;
  cp_kind_e         kind;
  logic [3:0]       cp_len;

  // character select for the current run position
  logic             hsel;
  logic [3:0]       jj_wide;
  logic [2:0]       jj;
  logic [15:0]      hword;
  logic [CharW-1:0] hex_char;
  logic [CharW-1:0] sel_char;

  // output side: one character moves into the output register per cycle unless out_o stalls
  assign load        = run_valid_q && (!out_valid_q || out_o.ready);
  assign run_at_last = run_idx_q == (run_len_q - 4'd1);

  // a new transaction may enter when no run is pending or once the pending run hands over its final character
  assign in_i.ready = !run_valid_q || (load && run_at_last);
  assign in_acc     = in_i.valid && in_i.ready;

  assign acc_shift = {code_accum_q[CodeW-7:0], in_i.in_byte[5:0]};
  assign pend_dec  = bytes_pending_q - 2'd1;

  // state update and code point extraction
  always_comb begin
    bytes_pending_d = bytes_pending_q;
    code_accum_d    = code_accum_q;
    emit_cp         = 1'b0;
    emit_quote      = 1'b0;
    cp              = CP_REPL;
    if (in_acc) begin
      unique case (in_i.action)
        ACT_BEGIN: begin
          // a sequence still open is dropped without a trace
          bytes_pending_d = 2'd0;
          code_accum_d    = '0;
          emit_quote      = 1'b1;
        end
        ACT_DATA: begin
          if (bytes_pending_q != 2'd0) begin
            // continuation bytes are taken on trust, low six bits only
            bytes_pending_d = pend_dec;
            code_accum_d    = acc_shift;
            if (pend_dec == 2'd0) begin
              emit_cp      = 1'b1;
              cp           = acc_shift;
              code_accum_d = '0;
            end
          end else if (in_i.in_byte <= ASCII_HI) begin
            emit_cp = 1'b1;
            cp      = {13'd0, in_i.in_byte};
          end else if (in_i.in_byte >= LEAD2_LO && in_i.in_byte <= LEAD2_HI) begin
            code_accum_d    = {16'd0, in_i.in_byte[4:0]};
            bytes_pending_d = 2'd1;
          end else if (in_i.in_byte >= LEAD3_LO && in_i.in_byte <= LEAD3_HI) begin
            code_accum_d    = {17'd0, in_i.in_byte[3:0]};
            bytes_pending_d = 2'd2;
          end else if (in_i.in_byte >= LEAD4_LO && in_i.in_byte <= LEAD4_HI) begin
            code_accum_d    = {18'd0, in_i.in_byte[2:0]};
            bytes_pending_d = 2'd3;
          end else begin
            // stray continuation or invalid lead byte
            emit_cp = 1'b1;
            cp      = CP_REPL;
          end
        end
        ACT_END: begin
          // a truncated sequence turns into the replacement character
          emit_cp         = bytes_pending_q != 2'd0;
          cp              = CP_REPL;
          bytes_pending_d = 2'd0;
          code_accum_d    = '0;
          emit_quote      = 1'b1;
        end
        default: begin
          // unused action code: no characters, state kept
        end
      endcase
    end
  end

  // classify the code point
  always_comb begin
    esc_char = '0;
    unique case (cp)
      CP_QUOTE:  esc_char = CH_QUOTE;
      CP_BSLASH: esc_char = CH_BSLASH;
      CP_BS:     esc_char = CH_B;
      CP_FF:     esc_char = CH_F;
      CP_LF:     esc_char = CH_N;
      CP_CR:     esc_char = CH_R;
      CP_TAB:    esc_char = CH_T;
      default:   esc_char = '0;
    endcase
  end

  assign supp_off = cp - CP_SUPP;

  always_comb begin
    run_w0_d = {9'd0, esc_char};
    run_w1_d = '0;
    priority if (!emit_cp) begin
      kind   = K_NONE;
      cp_len = 4'd0;
    end else if (esc_char != '0) begin
      kind   = K_ESC;
      cp_len = 4'd2;
    end else if (cp >= CP_PRT_LO && cp <= CP_PRT_HI) begin
      kind     = K_LIT;
      cp_len   = 4'd1;
      run_w0_d = {9'd0, cp[CharW-1:0]};
    end else if (cp < CP_SUPP) begin
      kind     = K_HEX;
      cp_len   = 4'd6;
      run_w0_d = cp[15:0];
    end else begin
      // surrogate pair from the low 20 bits of the offset
      kind     = K_PAIR;
      cp_len   = 4'd12;
      run_w0_d = {SURR_HI_PFX, supp_off[19:10]};
      run_w1_d = {SURR_LO_PFX, supp_off[9:0]};
    end
  end

  assign run_kind_d   = kind;
  assign run_cp_len_d = cp_len;
  assign run_len_d    = cp_len + {3'd0, emit_quote};

  // run register control
  always_comb begin
    run_valid_d = run_valid_q;
    run_idx_d   = run_idx_q;
    if (load) begin
      run_idx_d = run_idx_q + 4'd1;
      if (run_at_last) begin
        run_valid_d = 1'b0;
      end
    end
    if (in_acc) begin
      // transactions that only move the decoder state give no run
      run_valid_d = emit_cp || emit_quote;
      run_idx_d   = '0;
    end
  end

  // spell out the character at the current run position
  assign hsel    = run_idx_q >= 4'd6;
  assign jj_wide = hsel ? (run_idx_q - 4'd6) : run_idx_q;
  assign jj      = jj_wide[2:0];
  assign hword   = hsel ? run_w1_q : run_w0_q;

  always_comb begin
    unique case (jj)
      3'd2:    hex_char = hex_digit(hword[15:12]);
      3'd3:    hex_char = hex_digit(hword[11:8]);
      3'd4:    hex_char = hex_digit(hword[7:4]);
      3'd5:    hex_char = hex_digit(hword[3:0]);
      3'd1:    hex_char = CH_U;
      default: hex_char = CH_BSLASH;
    endcase
  end

  always_comb begin
    if (run_idx_q >= run_cp_len_q) begin
      // closing or opening quote follows the code point
      sel_char = CH_QUOTE;
    end else begin
      unique case (run_kind_q)
        K_ESC:   sel_char = (run_idx_q == 4'd0) ? CH_BSLASH : run_w0_q[CharW-1:0];
        K_LIT:   sel_char = run_w0_q[CharW-1:0];
        K_HEX:   sel_char = hex_char;
        K_PAIR:  sel_char = hex_char;
        K_NONE:  sel_char = CH_QUOTE;
        default: sel_char = CH_QUOTE;
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_char_d  = sel_char;
      out_last_d  = run_at_last;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_char = out_char_q;
  assign out_o.run_last = out_last_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_pending_q <= '0;
      code_accum_q    <= '0;
      run_valid_q     <= 1'b0;
      run_idx_q       <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      bytes_pending_q <= bytes_pending_d;
      code_accum_q    <= code_accum_d;
      run_valid_q     <= run_valid_d;
      run_idx_q       <= run_idx_d;
      out_valid_q     <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      run_kind_q   <= run_kind_d;
      run_cp_len_q <= run_cp_len_d;
      run_len_q    <= run_len_d;
      run_w0_q     <= run_w0_d;
      run_w1_q     <= run_w1_d;
    end
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  // the run position never runs past the run's length
  `U8JSE_ASSERT_NOW(a_idx_in_run, run_valid_q, run_idx_q < run_len_q, "run index past run end")

  // with no sequence open, the code point accumulator is idle
  `U8JSE_ASSERT_NOW(a_accum_idle, bytes_pending_q == 2'd0, code_accum_q == '0,
    "accumulator holds bits with no sequence open")

  // a begin transaction leaves the decoder clear and a single-quote run behind
  `U8JSE_ASSERT_NEXT(a_begin_run, in_acc && in_i.action == ACT_BEGIN,
    run_valid_q && run_len_q == 4'd1 && bytes_pending_q == 2'd0, "begin did not give a quote")

endmodule

### tb/testbench.sv
// self-checking testbench for the utf8 to json string escaper
`timescale 1ns / 100ps

module testbench;
  import u8jse_pkg::*;

  // action code that the escaper ignores
  localparam logic [ActionW-1:0] ACT_NONE = 2'd3;

  // number of random transactions after the directed table
  localparam int unsigned RandItems = 232;

  // worst case is far below this: ~300 items, 12 characters each, with the longest gaps that pick_gap gives
  localparam int unsigned CycleLimit = 400000;

  // cycles to wait after the last character, the escaper's latency with margin
  localparam int unsigned TailCycles = 20;

  // one expected output character
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } esc_char_t;

  // one row of the directed table; an empty text means the predictor decides
  typedef struct {
    logic [ActionW-1:0] act;
    logic [ByteW-1:0]   data;
    string              text;
  } dir_row_t;

  logic clk;
  logic rst_n;

  u8jse_in_if  in_ch ();
  u8jse_out_if out_ch ();

  utf8_to_json_string_escape DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // predictor state, a private copy of the decoder registers
  logic [1:0]       pend_cnt;
  logic [CodeW-1:0] cp_accum;

  // characters caused by the transaction being predicted
  logic [CharW-1:0] run_chars [$];

  // characters still due from the escaper, oldest first
  esc_char_t due_chars [$];

  dir_row_t dir_rows [$];

  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned items_sent;

  // when set, the sender puts no gaps between transactions
  bit send_no_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void put_char(input logic [CharW-1:0] c);
    run_chars.insert(run_chars.size(), c);
  endfunction

  // two-character escape, backslash then the letter
  function automatic void put_escape(input logic [CharW-1:0] c);
    put_char(CH_BSLASH);
    put_char(c);
  endfunction

  // backslash, u, four lowercase hex digits
  function automatic void put_hex4(input logic [15:0] v);
    string digits;
    digits = "0123456789abcdef";
    put_escape(CH_U);
    for (int s = 12; s >= 0; s -= 4) begin
      put_char(7'(digits[(v >> s) & 16'hF]));
    end
  endfunction

  function automatic void put_code_point(input logic [CodeW-1:0] cp);
    logic [CodeW-1:0] ofs;
    case (cp)
      CP_QUOTE:  put_escape(CH_QUOTE);
      CP_BSLASH: put_escape(CH_BSLASH);
      CP_BS:     put_escape(CH_B);
      CP_FF:     put_escape(CH_F);
      CP_LF:     put_escape(CH_N);
      CP_CR:     put_escape(CH_R);
      CP_TAB:    put_escape(CH_T);
      default: begin
        if (cp >= CP_PRT_LO && cp <= CP_PRT_HI) begin
          // printable ascii (slash included) and del pass straight through
          put_char(cp[CharW-1:0]);
        end else if (cp < CP_SUPP) begin
          put_hex4(cp[15:0]);
        end else begin
          // surrogate pair; the high half keeps only ten bits of the offset
          ofs = cp - CP_SUPP;
          put_hex4({SURR_HI_PFX, ofs[19:10]});
          put_hex4({SURR_LO_PFX, ofs[9:0]});
        end
      end
    endcase
  endfunction

  // advance the predicted decoder by one transaction, filling run_chars
  function automatic void escape_step(input logic [ActionW-1:0] act,
                                      input logic [ByteW-1:0] b);
    run_chars.delete();
    case (act)
      ACT_BEGIN: begin
        // a pending sequence is dropped without a replacement
        pend_cnt = 2'd0;
        cp_accum = '0;
        put_char(CH_QUOTE);
      end
      ACT_DATA: begin
        if (pend_cnt != 2'd0) begin
          // continuation bytes are taken as they come, only the low six bits count
          cp_accum = {cp_accum[CodeW-7:0], b[5:0]};
          pend_cnt = pend_cnt - 2'd1;
          if (pend_cnt == 2'd0) begin
            put_code_point(cp_accum);
            cp_accum = '0;
          end
        end else if (b <= ASCII_HI) begin
          put_code_point({13'd0, b});
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
          cp_accum = {16'd0, b[4:0]};
          pend_cnt = 2'd1;
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
          cp_accum = {17'd0, b[3:0]};
          pend_cnt = 2'd2;
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
          cp_accum = {18'd0, b[2:0]};
          pend_cnt = 2'd3;
        end else begin
          // stray continuation or a lead byte that can never be valid
          put_code_point(CP_REPL);
        end
      end
      ACT_END: begin
        // a truncated sequence is closed with a replacement character
        if (pend_cnt != 2'd0) begin
          put_code_point(CP_REPL);
        end
        pend_cnt = 2'd0;
        cp_accum = '0;
        put_char(CH_QUOTE);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap(input bit no_idle);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(8, 30);
    end
  endfunction

  // predict an accepted transaction and queue its characters;
  // a non-empty text overrides the predicted characters
  function automatic void note_accepted(input logic [ActionW-1:0] act,
                                        input logic [ByteW-1:0] b,
                                        input string text);
    esc_char_t entry;
    escape_step(act, b);
    if (text.len() > 0) begin
      run_chars.delete();
      for (int i = 0; i < text.len(); i++) begin
        run_chars.insert(run_chars.size(), 7'(text[i]));
      end
    end
    foreach (run_chars[i]) begin
      entry.ch   = run_chars[i];
      entry.last = (i == run_chars.size() - 1);
      due_chars.insert(due_chars.size(), entry);
    end
  endfunction

  // drive one transaction and hold it until it is taken; called at a clock edge
  task automatic send_item(input logic [ActionW-1:0] act, input logic [ByteW-1:0] b,
                           input string text = "");
    int unsigned gap;
    gap = pick_gap(send_no_idle);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    note_accepted(act, b, text);
    if (act != ACT_NONE) begin
      items_sent++;
    end
  endtask

  // hold off the sender until every queued character has come out
  task automatic drain_output();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (due_chars.size() != 0);
  endtask

  function automatic logic [CodeW-1:0] random_code_point();
    logic [CodeW-1:0] pick [8];
    pick = '{CP_BS, CP_TAB, CP_LF, CP_FF, CP_CR, CP_QUOTE, CP_BSLASH, 21'h2F};
    case ($urandom_range(0, 5))
      0:       return 21'($urandom_range(0, 'h7F));
      1:       return pick[$urandom_range(0, 7)];
      2:       return 21'($urandom_range('h80, 'h7FF));
      3:       return 21'($urandom_range('h800, 'hFFFF));
      4:       return 21'($urandom_range('h10000, 'h10FFFF));
      default: return 21'($urandom_range(0, 'h1F));
    endcase
  endfunction

  // shortest utf-8 encoding of a code point
  task automatic send_code_point(input logic [CodeW-1:0] cp);
    if (cp < 'h80) begin
      send_item(ACT_DATA, cp[7:0]);
    end else if (cp < 'h800) begin
      send_item(ACT_DATA, {3'b110, cp[10:6]});
      send_item(ACT_DATA, {2'b10, cp[5:0]});
    end else if (cp < 'h10000) begin
      send_item(ACT_DATA, {4'b1110, cp[15:12]});
      send_item(ACT_DATA, {2'b10, cp[11:6]});
      send_item(ACT_DATA, {2'b10, cp[5:0]});
    end else begin
      send_item(ACT_DATA, {5'b11110, cp[20:18]});
      send_item(ACT_DATA, {2'b10, cp[17:12]});
      send_item(ACT_DATA, {2'b10, cp[11:6]});
      send_item(ACT_DATA, {2'b10, cp[5:0]});
    end
  endtask

  // a lead byte followed by too few continuation bytes, cut off by end or begin
  task automatic send_truncated();
    int unsigned need;
    logic [ByteW-1:0] lead;
    need = $urandom_range(1, 3);
    case (need)
      1:       lead = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
      2:       lead = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
      default: lead = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
    endcase
    send_item(ACT_DATA, lead);
    repeat ($urandom_range(0, need - 1)) send_item(ACT_DATA, 8'($urandom_range('h80, 'hBF)));
    send_item(($urandom_range(0, 2) == 0) ? ACT_BEGIN : ACT_END, 8'($urandom));
  endtask

  function automatic void add_row(input logic [ActionW-1:0] act, input logic [ByteW-1:0] b,
                                  input string text);
    dir_row_t row;
    row.act  = act;
    row.data = b;
    row.text = text;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------

  initial begin
    bit drained;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.action  <= ACT_BEGIN;
    in_ch.in_byte <= '0;
    pend_cnt      = 2'd0;
    cp_accum      = '0;
    err_count     = 0;
    items_sent    = 0;
    send_no_idle  = 1'b0;
    drained       = 1'b0;

    // directed table: texts are given where they are obvious
    add_row(ACT_DATA,  8'h41, "A");            // data before any begin
    add_row(ACT_BEGIN, 8'h00, "\"");
    add_row(ACT_DATA,  8'h00, "\\u0000");
    add_row(ACT_DATA,  8'h22, "\\\"");
    add_row(ACT_DATA,  8'h5C, "\\\\");
    add_row(ACT_DATA,  8'h08, "\\b");
    add_row(ACT_DATA,  8'h0C, "\\f");
    add_row(ACT_DATA,  8'h0A, "\\n");
    add_row(ACT_DATA,  8'h0D, "\\r");
    add_row(ACT_DATA,  8'h09, "\\t");
    add_row(ACT_DATA,  8'h2F, "/");            // slash is not escaped
    add_row(ACT_DATA,  8'h7F, "");
    add_row(ACT_DATA,  8'h80, "\\ufffd");      // stray continuation byte
    add_row(ACT_DATA,  8'hFF, "\\ufffd");      // lead byte that is never valid
    add_row(ACT_DATA,  8'hDF, "");             // highest two-byte code point
    add_row(ACT_DATA,  8'hBF, "");
    add_row(ACT_DATA,  8'hF4, "");             // highest four-byte code point, pair out
    add_row(ACT_DATA,  8'h8F, "");
    add_row(ACT_DATA,  8'hBF, "");
    add_row(ACT_DATA,  8'hBF, "");
    add_row(ACT_DATA,  8'hEF, "");             // sequence cut off by end
    add_row(ACT_END,   8'h00, "\\ufffd\"");
    add_row(ACT_NONE,  8'h5A, "");             // unused action, no output
    add_row(ACT_DATA,  8'hF0, "");             // sequence dropped by begin
    add_row(ACT_BEGIN, 8'h00, "\"");
    add_row(ACT_DATA,  8'hC2, "");             // unchecked continuation byte
    add_row(ACT_DATA,  8'hFF, "");
    add_row(ACT_END,   8'h00, "\"");

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].act, dir_rows[i].data, dir_rows[i].text);
    end
    drain_output();

    // random part: mostly well-formed strings, some broken ones and noise
    while (items_sent < dir_rows.size() + RandItems) begin
      send_no_idle = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        7: begin
          send_item(ACT_BEGIN, 8'($urandom));
          repeat ($urandom_range(0, 3)) send_code_point(random_code_point());
          send_truncated();
        end
        8, 9: begin
          repeat ($urandom_range(1, 6)) send_item(2'($urandom_range(0, 3)), 8'($urandom));
        end
        default: begin
          send_item(ACT_BEGIN, 8'($urandom));
          repeat ($urandom_range(1, 8)) send_code_point(random_code_point());
          send_item(ACT_END, 8'($urandom));
        end
      endcase
      // let the output run dry at least once in the middle of the run
      if (!drained && items_sent >= dir_rows.size() + RandItems / 2) begin
        drained = 1'b1;
        drain_output();
      end
    end

    send_no_idle = 1'b0;
    drain_output();
    repeat (TailCycles) @(posedge clk);

    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: random backpressure with long stretches of ready
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned gap;
    out_ch.ready <= 1'b0;
    forever begin
      gap = pick_gap(1'b0);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(20, 60)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output check: every character transaction against the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    esc_char_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none, actual %h last %b",
                 $time, out_ch.out_char, out_ch.run_last);
        err_count++;
      end else begin
        want = due_chars.pop_front();
        if (out_ch.out_char !== want.ch) begin
          $display("%0t: out_char expected %h actual %h", $time, want.ch, out_ch.out_char);
          err_count++;
        end
        if (out_ch.run_last !== want.last) begin
          $display("%0t: run_last expected %b actual %b", $time, want.last, out_ch.run_last);
          err_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

endmodule
